[rtl/core/cyclic_gradient_palette_lookup_core_assert.svh]
// Assertion macros shared by the checker of the palette lookup core.
`ifndef CYCLIC_GRADIENT_PALETTE_LOOKUP_CORE_ASSERT_SVH
`define CYCLIC_GRADIENT_PALETTE_LOOKUP_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define CGPL_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CGPL_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/cgpl_pkg.sv]
package cgpl_pkg;

  localparam int MAX_PRIMARIES = 16;
  localparam int MAX_GRADIENTS = 255;

  localparam int SLOT_W     = 4;
  localparam int GS_W       = 8;
  localparam int PC_W       = 5;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 3;
  localparam int COLOR_W    = NUM_CH * CH_W;
  localparam int IDX_W      = 12;
  localparam int DIV_W      = GS_W + 1;
  localparam int LIMIT_W    = IDX_W + 1;
  localparam int PROD_W     = DIV_W + CH_W;
  localparam int NUM_W      = PROD_W + 1;
  localparam int QDIV_STEPS = SLOT_W;
  localparam int BDIV_STEPS = CH_W;

  localparam int MID_DEPTH  = 4;
  localparam int MID_PTR_W  = $clog2(MID_DEPTH);
  localparam int MID_CNT_W  = MID_PTR_W + 1;
  localparam int OUT_DEPTH  = 32;
  localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W  = OUT_PTR_W + 1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int GS_LIMIT   = (MAX_GRADIENTS < 255) ? MAX_GRADIENTS : 255;
  localparam int PC_LIMIT   = (MAX_PRIMARIES < 16) ? MAX_PRIMARIES : 16;

  typedef enum logic {
    OP_WRITE,
    OP_QUERY
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRADIENT_STEPS,
    REG_PRIMARY_COUNT
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_QUERY,
    KIND_RANGE
  } kind_e;

  typedef struct packed {
    logic              operation;
    logic [SLOT_W-1:0] slot;
    logic [CH_W-1:0]   red_in;
    logic [CH_W-1:0]   green_in;
    logic [CH_W-1:0]   blue_in;
    logic [IDX_W-1:0]  entry_index;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            index_error;
  } out_item_t;

  typedef struct packed {
    kind_e              kind;
    logic [SLOT_W-1:0]  slot;
    logic [COLOR_W-1:0] color;
    logic [IDX_W-1:0]   entry_index;
  } token_t;

  typedef struct packed {
    logic [GS_W-1:0] gradient_steps;
    logic [PC_W-1:0] primary_count;
  } cfg_t;

endpackage

[rtl/core/cgpl_front.sv]
module cgpl_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cgpl_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [cgpl_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  cgpl_pkg::in_item_t                  item_i,
  output cgpl_pkg::token_t                    tok_o,
  output cgpl_pkg::cfg_t                      cfg_o
);

  localparam int GS_W     = cgpl_pkg::GS_W;
  localparam int PC_W     = cgpl_pkg::PC_W;
  localparam int LIMIT_W  = cgpl_pkg::LIMIT_W;
  localparam int DATA_W   = cgpl_pkg::CFG_DATA_W;

  logic [GS_W-1:0]    gs_q, gs_d;
  logic [PC_W-1:0]    pc_q, pc_d;
  logic [LIMIT_W-1:0] limit;

  // Register writes; out-of-range values leave the register alone.
  always_comb begin
    gs_d = gs_q;
    pc_d = pc_q;
    if (cfg_we_i) begin
      case (cgpl_pkg::cfg_reg_e'(cfg_idx_i))
        cgpl_pkg::REG_GRADIENT_STEPS: begin
          if (cfg_data_i <= DATA_W'(cgpl_pkg::GS_LIMIT)) begin
            gs_d = GS_W'(cfg_data_i);
          end
        end
        cgpl_pkg::REG_PRIMARY_COUNT: begin
          if ((cfg_data_i != '0) && (cfg_data_i <= DATA_W'(cgpl_pkg::PC_LIMIT))) begin
            pc_d = PC_W'(cfg_data_i);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gs_q <= '0;
      pc_q <= PC_W'(1);
    end else begin
      gs_q <= gs_d;
      pc_q <= pc_d;
    end
  end

  // Palette length is (G+1)*P.
  assign limit = (LIMIT_W'(gs_q) + LIMIT_W'(1)) * LIMIT_W'(pc_q);

  always_comb begin
    tok_o.slot        = item_i.slot;
    tok_o.color       = {item_i.red_in, item_i.green_in, item_i.blue_in};
    tok_o.entry_index = item_i.entry_index;
    if (cgpl_pkg::op_e'(item_i.operation) == cgpl_pkg::OP_WRITE) begin
      tok_o.kind = cgpl_pkg::KIND_WRITE;
    end else if (LIMIT_W'(item_i.entry_index) >= limit) begin
      tok_o.kind = cgpl_pkg::KIND_RANGE;
    end else begin
      tok_o.kind = cgpl_pkg::KIND_QUERY;
    end
  end

  assign cfg_o.gradient_steps = gs_q;
  assign cfg_o.primary_count  = pc_q;

endmodule

[rtl/core/cgpl_mid_queue.sv]
module cgpl_mid_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  cgpl_pkg::token_t tok_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output cgpl_pkg::token_t tok_o
);

  localparam int PTR_W = cgpl_pkg::MID_PTR_W;
  localparam int CNT_W = cgpl_pkg::MID_CNT_W;

  cgpl_pkg::token_t mem_q [cgpl_pkg::MID_DEPTH];
  cgpl_pkg::token_t head_q;
  logic             head_v_q;
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] mem_cnt_q;
  logic             head_free;
  logic             load;
  logic             bypass;
  logic             mem_wr;

  assign full_o    = (cnt_q == CNT_W'(cgpl_pkg::MID_DEPTH));
  assign empty_o   = !head_v_q;
  assign tok_o     = head_q;
  assign head_free = !head_v_q || pop_i;
  assign load      = (mem_cnt_q != '0) && head_free;
  assign bypass    = push_i && (mem_cnt_q == '0) && head_free;
  assign mem_wr    = push_i && !bypass;

  // Refill the head from memory; a push into an idle queue goes straight to the head.
  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      mem_q[wr_ptr_q] <= tok_i;
    end
    if (load) begin
      head_q <= mem_q[rd_ptr_q];
    end else if (bypass) begin
      head_q <= tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      mem_cnt_q <= '0;
      head_v_q  <= 1'b0;
      cnt_q     <= '0;
    end else begin
      wr_ptr_q  <= wr_ptr_q + PTR_W'(mem_wr);
      rd_ptr_q  <= rd_ptr_q + PTR_W'(load);
      mem_cnt_q <= mem_cnt_q + CNT_W'(mem_wr) - CNT_W'(load);
      head_v_q  <= load || bypass || (head_v_q && !pop_i);
      cnt_q     <= cnt_q + CNT_W'(push_i) - CNT_W'(pop_i);
    end
  end

endmodule

[rtl/core/cgpl_back.sv]
module cgpl_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cgpl_pkg::cfg_t      cfg_i,
  input  cgpl_pkg::token_t    mid_tok_i,
  input  logic                mid_empty_i,
  output logic                mid_pop_o,
  input  logic                res_pop_i,
  output logic                res_push_o,
  output cgpl_pkg::out_item_t res_item_o
);

  localparam int SLOT_W  = cgpl_pkg::SLOT_W;
  localparam int GS_W    = cgpl_pkg::GS_W;
  localparam int PC_W    = cgpl_pkg::PC_W;
  localparam int CH_W    = cgpl_pkg::CH_W;
  localparam int NUM_CH  = cgpl_pkg::NUM_CH;
  localparam int COLOR_W = cgpl_pkg::COLOR_W;
  localparam int IDX_W   = cgpl_pkg::IDX_W;
  localparam int DIV_W   = cgpl_pkg::DIV_W;
  localparam int PROD_W  = cgpl_pkg::PROD_W;
  localparam int NUM_W   = cgpl_pkg::NUM_W;
  localparam int QS      = cgpl_pkg::QDIV_STEPS;
  localparam int BS      = cgpl_pkg::BDIV_STEPS;
  localparam int CNT_W   = cgpl_pkg::OUT_CNT_W;
  localparam int QSUB_W  = IDX_W + 1;
  localparam int BSUB_W  = NUM_W + 1;

  logic [DIV_W-1:0] d;
  logic             issue;
  logic             wr;
  logic [CNT_W-1:0] res_q;

  assign d         = DIV_W'(cfg_i.gradient_steps) + DIV_W'(1);
  assign issue     = !mid_empty_i && (res_q < CNT_W'(cgpl_pkg::OUT_DEPTH));
  assign mid_pop_o = issue;

  // Index divider: one quotient bit per stage, yields primary and step.
  logic [QS-1:0]         qv_q;
  cgpl_pkg::token_t      qt_q [QS];
  cgpl_pkg::token_t      qt_d [QS];
  logic [IDX_W-1:0]      qr_q [QS];
  logic [IDX_W-1:0]      qr_d [QS];
  logic [SLOT_W-1:0]     qq_q [QS];
  logic [SLOT_W-1:0]     qq_d [QS];

  always_comb begin
    logic [IDX_W-1:0]  rin;
    logic [SLOT_W-1:0] qin;
    logic [QSUB_W-1:0] sub;
    logic              ge;
    for (int s = 0; s < QS; s++) begin
      if (s == 0) begin
        rin     = mid_tok_i.entry_index;
        qin     = '0;
        qt_d[s] = mid_tok_i;
      end else begin
        rin     = qr_q[s-1];
        qin     = qq_q[s-1];
        qt_d[s] = qt_q[s-1];
      end
      sub     = QSUB_W'(d) << (QS - 1 - s);
      ge      = (QSUB_W'(rin) >= sub);
      qr_d[s] = ge ? (rin - sub[IDX_W-1:0]) : rin;
      qq_d[s] = (qin << 1) | SLOT_W'(ge);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < QS; s++) begin
      qt_q[s] <= qt_d[s];
      qr_q[s] <= qr_d[s];
      qq_q[s] <= qq_d[s];
    end
  end

  // Table stage: write primaries in order, read the pair for a query.
  cgpl_pkg::token_t          rt;
  logic [SLOT_W-1:0]         prim;
  logic [SLOT_W-1:0]         nxt;
  logic [PC_W-1:0]           prim_inc;
  logic [COLOR_W-1:0]        tbl_q [cgpl_pkg::MAX_PRIMARIES];
  logic [cgpl_pkg::MAX_PRIMARIES-1:0] tbl_vld_q;
  logic [COLOR_W-1:0]        ca_q, cb_q;
  logic                      va_q, vb_q;
  logic                      rd_v_q, rd_err_q;
  logic [GS_W-1:0]           rd_g_q;

  assign rt       = qt_q[QS-1];
  assign prim     = qq_q[QS-1];
  assign prim_inc = PC_W'(prim) + PC_W'(1);
  assign nxt      = (prim_inc >= cfg_i.primary_count) ? '0 : prim_inc[SLOT_W-1:0];
  assign wr       = qv_q[QS-1] && (rt.kind == cgpl_pkg::KIND_WRITE);

  always_ff @(posedge clk_i) begin
    if (wr) begin
      tbl_q[rt.slot] <= rt.color;
    end
    ca_q     <= tbl_q[prim];
    cb_q     <= tbl_q[nxt];
    va_q     <= tbl_vld_q[prim];
    vb_q     <= tbl_vld_q[nxt];
    rd_err_q <= (rt.kind == cgpl_pkg::KIND_RANGE);
    rd_g_q   <= qr_q[QS-1][GS_W-1:0];
  end

  // Products (d-g)*a and g*b per channel.
  logic [PROD_W-1:0] pa_q [NUM_CH];
  logic [PROD_W-1:0] pb_q [NUM_CH];
  logic [CH_W-1:0]   ch_a [NUM_CH];
  logic [CH_W-1:0]   ch_b [NUM_CH];
  logic [DIV_W-1:0]  dg;
  logic              mul_v_q, mul_err_q;

  assign dg = d - DIV_W'(rd_g_q);

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      ch_a[c] = va_q ? ca_q[COLOR_W-1-CH_W*c -: CH_W] : '0;
      ch_b[c] = vb_q ? cb_q[COLOR_W-1-CH_W*c -: CH_W] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NUM_CH; c++) begin
      pa_q[c] <= PROD_W'(dg) * PROD_W'(ch_a[c]);
      pb_q[c] <= PROD_W'(rd_g_q) * PROD_W'(ch_b[c]);
    end
    mul_err_q <= rd_err_q;
  end

  // Numerator 2n + d for half-up rounding.
  logic [NUM_W-1:0]  num_q [NUM_CH];
  logic [PROD_W-1:0] nsum  [NUM_CH];
  logic              sum_v_q, sum_err_q;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      nsum[c] = pa_q[c] + pb_q[c];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NUM_CH; c++) begin
      num_q[c] <= {nsum[c], 1'b0} + NUM_W'(d);
    end
    sum_err_q <= mul_err_q;
  end

  // Blend divider by 2d: one result bit per stage, three channels side by side.
  logic [BS-1:0]     bv_q;
  logic [BS-1:0]     be_q;
  logic [NUM_W-1:0]  br_q [BS][NUM_CH];
  logic [NUM_W-1:0]  br_d [BS][NUM_CH];
  logic [CH_W-1:0]   bq_q [BS][NUM_CH];
  logic [CH_W-1:0]   bq_d [BS][NUM_CH];
  logic [BSUB_W-1:0] dd;

  assign dd = BSUB_W'({d, 1'b0});

  always_comb begin
    logic [NUM_W-1:0]  rin;
    logic [CH_W-1:0]   qin;
    logic [BSUB_W-1:0] sub;
    logic              ge;
    for (int s = 0; s < BS; s++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        if (s == 0) begin
          rin = num_q[c];
          qin = '0;
        end else begin
          rin = br_q[s-1][c];
          qin = bq_q[s-1][c];
        end
        sub        = dd << (BS - 1 - s);
        ge         = (BSUB_W'(rin) >= sub);
        br_d[s][c] = ge ? (rin - sub[NUM_W-1:0]) : rin;
        bq_d[s][c] = (qin << 1) | CH_W'(ge);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < BS; s++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        br_q[s][c] <= br_d[s][c];
        bq_q[s][c] <= bq_d[s][c];
      end
    end
    be_q <= {be_q[BS-2:0], sum_err_q};
  end

  // Valid bits, table valid bits and the output-slot reservation count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qv_q      <= '0;
      rd_v_q    <= 1'b0;
      mul_v_q   <= 1'b0;
      sum_v_q   <= 1'b0;
      bv_q      <= '0;
      tbl_vld_q <= '0;
      res_q     <= '0;
    end else begin
      qv_q    <= {qv_q[QS-2:0], issue};
      rd_v_q  <= qv_q[QS-1] && !wr;
      mul_v_q <= rd_v_q;
      sum_v_q <= mul_v_q;
      bv_q    <= {bv_q[BS-2:0], sum_v_q};
      if (wr) begin
        tbl_vld_q[rt.slot] <= 1'b1;
      end
      res_q <= res_q + CNT_W'(issue) - CNT_W'(res_pop_i) - CNT_W'(wr);
    end
  end

  assign res_push_o              = bv_q[BS-1];
  assign res_item_o.index_error  = be_q[BS-1];
  assign res_item_o.out_red      = be_q[BS-1] ? '0 : bq_q[BS-1][0];
  assign res_item_o.out_green    = be_q[BS-1] ? '0 : bq_q[BS-1][1];
  assign res_item_o.out_blue     = be_q[BS-1] ? '0 : bq_q[BS-1][2];

endmodule

[rtl/core/cgpl_out_queue.sv]
module cgpl_out_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  cgpl_pkg::out_item_t item_i,
  input  logic                pop_i,
  output logic                empty_o,
  output cgpl_pkg::out_item_t item_o
);

  localparam int PTR_W = cgpl_pkg::OUT_PTR_W;
  localparam int CNT_W = cgpl_pkg::OUT_CNT_W;

  cgpl_pkg::out_item_t mem_q [cgpl_pkg::OUT_DEPTH];
  cgpl_pkg::out_item_t head_q;
  logic                head_v_q;
  logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]    mem_cnt_q;
  logic                head_free;
  logic                load;
  logic                bypass;
  logic                mem_wr;

  assign empty_o   = !head_v_q;
  assign item_o    = head_q;
  assign head_free = !head_v_q || pop_i;
  assign load      = (mem_cnt_q != '0) && head_free;
  assign bypass    = push_i && (mem_cnt_q == '0) && head_free;
  assign mem_wr    = push_i && !bypass;

  // Refill the head from memory; a push into an idle queue goes straight to the head.
  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      mem_q[wr_ptr_q] <= item_i;
    end
    if (load) begin
      head_q <= mem_q[rd_ptr_q];
    end else if (bypass) begin
      head_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      mem_cnt_q <= '0;
      head_v_q  <= 1'b0;
    end else begin
      wr_ptr_q  <= wr_ptr_q + PTR_W'(mem_wr);
      rd_ptr_q  <= rd_ptr_q + PTR_W'(load);
      mem_cnt_q <= mem_cnt_q + CNT_W'(mem_wr) - CNT_W'(load);
      head_v_q  <= load || bypass || (head_v_q && !pop_i);
    end
  end

endmodule

[rtl/core/cyclic_gradient_palette_lookup_core.sv]
// Channel   Direction  Handshake                Word
// --------  ---------  -----------------------  -----------------------------------
// item      in         push / full              in_item_t: write primary or query
// result    out        empty / pop              out_item_t: color and index error
// config    in         cfg_we_i, no wait        cfg_idx_i selects, cfg_data_i value
//
// Takes one word per cycle while full is low and delivers one result per cycle when pop stays high.
// A query pushed into an idle core passes the front queue head, four index-divider
// stages, the table read, the multiply and sum stages, eight blend-divider stages
// and the output queue head before it shows on the result side.
// Reset clears the primary table to black via per-slot valid bits, G to 0, P to 1.
// A stalled result side fills the 32-word output queue; the back end stops drawing
// from the front queue and full rises once its four words are taken.
module cyclic_gradient_palette_lookup_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cgpl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cgpl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            push,
  output logic                            full,
  input  cgpl_pkg::in_item_t              item_i,
  output logic                            empty,
  input  logic                            pop,
  output cgpl_pkg::out_item_t             result_o
);

  cgpl_pkg::token_t    front_tok;
  cgpl_pkg::token_t    mid_tok;
  cgpl_pkg::cfg_t      cfg;
  cgpl_pkg::out_item_t res_item;
  logic                in_acc;
  logic                out_acc;
  logic                mid_empty;
  logic                mid_pop;
  logic                res_push;

  // Accept a word whenever the front queue has room.
  assign in_acc  = push && !full;
  assign out_acc = pop && !empty;

  // Front: hold the registers, classify each word as write, query or range miss.
  cgpl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_i),
    .tok_o      (front_tok),
    .cfg_o      (cfg)
  );

  // Decouple the front from the back so each side stalls on its own.
  cgpl_mid_queue u_mid_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_acc),
    .tok_i   (front_tok),
    .full_o  (full),
    .pop_i   (mid_pop),
    .empty_o (mid_empty),
    .tok_o   (mid_tok)
  );

  // Back: divide, read the table, blend; draw a word only when an output
  // slot is reserved for it, so the pipeline never has to stop.
  cgpl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .mid_tok_i   (mid_tok),
    .mid_empty_i (mid_empty),
    .mid_pop_o   (mid_pop),
    .res_pop_i   (out_acc),
    .res_push_o  (res_push),
    .res_item_o  (res_item)
  );

  // Hold finished results until the consumer takes them.
  cgpl_out_queue u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .item_i  (res_item),
    .pop_i   (out_acc),
    .empty_o (empty),
    .item_o  (result_o)
  );

endmodule

[rtl/core/cgpl_checker.sv]
`include "cyclic_gradient_palette_lookup_core_assert.svh"

module cgpl_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                push,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input cgpl_pkg::out_item_t result_o
);

  // A range miss carries black.
  `CGPL_ASSERT_IMP(a_err_black, clk_i, rst_ni, !empty && result_o.index_error, result_o.out_red == '0 && result_o.out_green == '0 && result_o.out_blue == '0, "index error with nonzero color")

  // An untaken result stays put.
  `CGPL_ASSERT_NXT(a_res_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(result_o), "waiting result changed")

  // The front queue fills only through an accepted word.
  `CGPL_ASSERT_IMP(a_full_src, clk_i, rst_ni, $rose(full), $past(push), "full rose without a push")

endmodule

bind cyclic_gradient_palette_lookup_core cgpl_checker u_cgpl_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push       (push),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .result_o   (result_o)
);
